>>> hdl/avc_to_annexb_converter_core_macros.svh
// assertion macros for the converter core checker
`ifndef AVC_TO_ANNEXB_CONVERTER_CORE_MACROS_SVH
`define AVC_TO_ANNEXB_CONVERTER_CORE_MACROS_SVH

// same-cycle implication
`define A2B_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define A2B_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/avc2ab_pkg.sv
// types, constants and helpers of the avc to annex b converter
package avc2ab_pkg;

	localparam int HEADER_BYTES_DEF = 56;
	localparam int TS_BITS_DEF      = 64;
	localparam int PERIOD_W         = 40;

	localparam logic [PERIOD_W-1:0] RESYNC_RESET = 40'd1000000000;
	localparam logic [7:0] LEN_SIZE_MASK  = 8'h03;
	localparam logic [7:0] SPS_COUNT_MASK = 8'h1f;
	localparam logic [7:0] START_CODE_END = 8'h01;
	localparam logic [7:0] START_CODE_PAD = 8'h00;

	typedef struct packed {
		logic        func;
		logic [7:0]  data_byte;
		logic        first;
		logic        last;
		logic        ts_valid;
		logic [62:0] timestamp;
	} in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
		logic       is_header;
		logic       unit_end;
		logic       header_overflow;
	} out_t;

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_SCW  = 7'b0000010,
		S_DIFF = 7'b0000100,
		S_EVAL = 7'b0001000,
		S_HRD  = 7'b0010000,
		S_HOUT = 7'b0100000,
		S_BODY = 7'b1000000
	} seq_state_t;

	typedef enum logic [7:0] {
		RS_SKIP  = 8'b00000001,
		RS_LENSZ = 8'b00000010,
		RS_NSPS  = 8'b00000100,
		RS_SZHI  = 8'b00001000,
		RS_SZLO  = 8'b00010000,
		RS_DATA  = 8'b00100000,
		RS_NPPS  = 8'b01000000,
		RS_IDLE  = 8'b10000000
	} rec_state_t;

	typedef enum logic [1:0] {
		BK_NONE = 2'd0,
		BK_BYTE = 2'd1,
		BK_SC   = 2'd2
	} body_kind_t;

	function automatic logic [7:0] sc_byte(input logic [1:0] k);
		return (k == 2'd3) ? START_CODE_END : START_CODE_PAD;
	endfunction

endpackage

>>> hdl/avc2ab_ram.sv
// generic single-write, single-read ram with registered read data
module avc2ab_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 56
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

>>> hdl/avc_to_annexb_converter_core.sv
// top level of the avc length-prefixed to annex b start-code converter
// One byte is taken per beat and the block is not ready again until that byte's
// work is done. A record byte is handled in the idle state; the low byte of a
// set size also writes the four start-code bytes into the header ram one per
// cycle over its single write port. A sample byte emits one payload byte, four
// start-code bytes or none, and a sample's first byte also passes through the
// timestamp subtract and compare states. When the stored header is sent, each
// header byte is read from the header ram (a registered read) and then emitted.
// The header ram is not cleared after reset; only entries written by the
// current record are read back.
module avc_to_annexb_converter_core #(
	parameter int HEADER_BYTES = avc2ab_pkg::HEADER_BYTES_DEF,
	parameter int TS_BITS      = avc2ab_pkg::TS_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	output logic                          item_ready,
	input  avc2ab_pkg::in_t               item_data,
	output logic                          res_valid,
	input  logic                          res_ready,
	output avc2ab_pkg::out_t              res_data,
	input  logic                          cfg_we,
	input  logic [avc2ab_pkg::PERIOD_W-1:0] cfg_wdata
);

	localparam int AW = $clog2(HEADER_BYTES);
	localparam int LW = $clog2(HEADER_BYTES + 1);
	localparam logic [LW-1:0] HB_L = LW'(HEADER_BYTES);

	avc2ab_pkg::seq_state_t state_q, state_d;
	avc2ab_pkg::rec_state_t rec_q, rec_d, rs_cur;
	avc2ab_pkg::body_kind_t kind_q, kind_d;

	logic [1:0]  skip_q, skip_d, skip_cur;
	logic [7:0]  sets_q, sets_d, sets_dec;
	logic        in_pps_q, in_pps_d;
	logic [15:0] set_left_q, set_left_d, set_left_new;
	logic [LW-1:0] hdr_len_q, hdr_len_d;
	logic        ovf_q, ovf_d;
	logic [2:0]  len_size_q, len_size_d;
	logic        pend_q, pend_d;
	logic        rsv_q, rsv_d;
	logic [TS_BITS-1:0] rts_q, rts_d;
	logic        in_pl_q, in_pl_d, in_pl_cur;
	logic [2:0]  pcnt_q, pcnt_d, pcnt_cur, pcnt_new, psize_cur;
	logic [2:0]  psize_q, psize_d;
	logic [31:0] pacc_q, pacc_d, pacc_new;
	logic [31:0] pleft_q, pleft_d, pleft_dec, nal;
	logic [avc2ab_pkg::PERIOD_W-1:0] period_q, period_d;
	logic [AW-1:0] idx_q, idx_d;
	logic [1:0]  sc_q, sc_d;
	logic [7:0]  byte_q, byte_d;
	logic        last_q, last_d;
	logic        tsv_q, tsv_d;
	logic [TS_BITS-1:0] ts_q, ts_d, diff_q, diff_d;
	avc2ab_pkg::out_t res_q, res_d;
	logic        res_valid_q, res_valid_d;

	logic        accept, can_emit, due, hdr_last, rl;
	logic        ram_we, ram_re;
	logic [AW-1:0] ram_waddr;
	logic [7:0]  ram_wdata, ram_rdata;
	avc2ab_pkg::seq_state_t after_hdr;

	avc2ab_ram #(
		.WIDTH(8),
		.DEPTH(HEADER_BYTES)
	) u_hdr_ram (
		.clk    (clk),
		.wr_en  (ram_we),
		.wr_addr(ram_waddr),
		.wr_data(ram_wdata),
		.rd_en  (ram_re),
		.rd_addr(idx_q),
		.rd_data(ram_rdata)
	);

	assign item_ready = (state_q == avc2ab_pkg::S_IDLE);
	assign accept     = item_valid && item_ready;
	assign can_emit   = !res_valid_q || res_ready;
	assign res_valid  = res_valid_q;
	assign res_data   = res_q;

	assign rs_cur    = item_data.first ? avc2ab_pkg::RS_SKIP : rec_q;
	assign skip_cur  = item_data.first ? 2'd0 : skip_q;
	assign sets_dec  = (sets_q == 8'd0) ? 8'd0 : sets_q - 8'd1;
	assign set_left_new = set_left_q - 16'd1;

	assign in_pl_cur = item_data.first ? 1'b0 : in_pl_q;
	assign pcnt_cur  = item_data.first ? 3'd0 : pcnt_q;
	assign psize_cur = (pcnt_cur == 3'd0) ? len_size_q : psize_q;
	assign pacc_new  = {((pcnt_cur == 3'd0) ? 24'd0 : pacc_q[23:0]), item_data.data_byte};
	assign pcnt_new  = pcnt_cur + 3'd1;
	assign pleft_dec = pleft_q - 32'd1;
	assign nal       = (psize_cur == 3'd3) ? 32'd0 : pacc_new;

	assign due = pend_q || (tsv_q && rsv_q && !diff_q[TS_BITS-1]
		&& (64'(diff_q) > 64'(period_q)));
	assign hdr_last  = (LW'(idx_q) + LW'(1)) == hdr_len_q;
	assign after_hdr = (kind_q != avc2ab_pkg::BK_NONE) ? avc2ab_pkg::S_BODY
		: avc2ab_pkg::S_IDLE;

	always_comb begin
		state_d     = state_q;
		rec_d       = rec_q;
		kind_d      = kind_q;
		skip_d      = skip_q;
		sets_d      = sets_q;
		in_pps_d    = in_pps_q;
		set_left_d  = set_left_q;
		hdr_len_d   = hdr_len_q;
		ovf_d       = ovf_q;
		len_size_d  = len_size_q;
		pend_d      = pend_q;
		rsv_d       = rsv_q;
		rts_d       = rts_q;
		in_pl_d     = in_pl_q;
		pcnt_d      = pcnt_q;
		psize_d     = psize_q;
		pacc_d      = pacc_q;
		pleft_d     = pleft_q;
		period_d    = cfg_we ? cfg_wdata : period_q;
		idx_d       = idx_q;
		sc_d        = sc_q;
		byte_d      = byte_q;
		last_d      = last_q;
		tsv_d       = tsv_q;
		ts_d        = ts_q;
		diff_d      = diff_q;
		res_d       = res_q;
		res_valid_d = res_valid_q && !res_ready;
		ram_we      = 1'b0;
		ram_re      = 1'b0;
		ram_waddr   = hdr_len_q[AW-1:0];
		ram_wdata   = item_data.data_byte;
		rl          = 1'b0;

		case (state_q)
			avc2ab_pkg::S_IDLE: begin
				if (accept && !item_data.func) begin
					if (item_data.first) begin
						hdr_len_d = '0;
						pend_d    = 1'b1;
					end
					case (rs_cur)
						avc2ab_pkg::RS_SKIP: begin
							skip_d = skip_cur + 2'd1;
							rec_d  = (skip_cur == 2'd3) ? avc2ab_pkg::RS_LENSZ
								: avc2ab_pkg::RS_SKIP;
						end
						avc2ab_pkg::RS_LENSZ: begin
							len_size_d = 3'(item_data.data_byte & avc2ab_pkg::LEN_SIZE_MASK)
								+ 3'd1;
							rec_d = avc2ab_pkg::RS_NSPS;
						end
						avc2ab_pkg::RS_NSPS: begin
							sets_d   = item_data.data_byte & avc2ab_pkg::SPS_COUNT_MASK;
							in_pps_d = 1'b0;
							rec_d = ((item_data.data_byte & avc2ab_pkg::SPS_COUNT_MASK) != 8'd0)
								? avc2ab_pkg::RS_SZHI : avc2ab_pkg::RS_NPPS;
						end
						avc2ab_pkg::RS_SZHI: begin
							set_left_d = {item_data.data_byte, 8'd0};
							rec_d      = avc2ab_pkg::RS_SZLO;
						end
						avc2ab_pkg::RS_SZLO: begin
							set_left_d = {set_left_q[15:8], item_data.data_byte};
							sc_d       = 2'd0;
							state_d    = avc2ab_pkg::S_SCW;
							if ({set_left_q[15:8], item_data.data_byte} == 16'd0) begin
								sets_d = sets_dec;
								if (sets_dec == 8'd0) begin
									rec_d = in_pps_q ? avc2ab_pkg::RS_IDLE : avc2ab_pkg::RS_NPPS;
								end else begin
									rec_d = avc2ab_pkg::RS_SZHI;
								end
							end else begin
								rec_d = avc2ab_pkg::RS_DATA;
							end
						end
						avc2ab_pkg::RS_DATA: begin
							if (hdr_len_q < HB_L) begin
								ram_we    = 1'b1;
								hdr_len_d = hdr_len_q + LW'(1);
							end else begin
								ovf_d = 1'b1;
							end
							set_left_d = set_left_new;
							if (set_left_new == 16'd0) begin
								sets_d = sets_dec;
								if (sets_dec == 8'd0) begin
									rec_d = in_pps_q ? avc2ab_pkg::RS_IDLE : avc2ab_pkg::RS_NPPS;
								end else begin
									rec_d = avc2ab_pkg::RS_SZHI;
								end
							end
						end
						avc2ab_pkg::RS_NPPS: begin
							sets_d   = item_data.data_byte;
							in_pps_d = 1'b1;
							rec_d    = (item_data.data_byte != 8'd0) ? avc2ab_pkg::RS_SZHI
								: avc2ab_pkg::RS_IDLE;
						end
						default: begin
						end
					endcase
					if (item_data.last) begin
						rec_d = avc2ab_pkg::RS_IDLE;
					end
				end else if (accept) begin
					byte_d = item_data.data_byte;
					last_d = item_data.last;
					tsv_d  = item_data.ts_valid;
					ts_d   = TS_BITS'(item_data.timestamp);
					sc_d   = 2'd0;
					if (in_pl_cur) begin
						kind_d  = avc2ab_pkg::BK_BYTE;
						pleft_d = pleft_dec;
						in_pl_d = (pleft_dec != 32'd0);
						pcnt_d  = pcnt_cur;
					end else begin
						psize_d = psize_cur;
						pacc_d  = pacc_new;
						in_pl_d = 1'b0;
						if (pcnt_new >= psize_cur) begin
							kind_d = avc2ab_pkg::BK_SC;
							pcnt_d = 3'd0;
							if (nal != 32'd0) begin
								in_pl_d = 1'b1;
								pleft_d = nal;
							end
						end else begin
							kind_d = avc2ab_pkg::BK_NONE;
							pcnt_d = pcnt_new;
						end
					end
					if (item_data.last) begin
						in_pl_d = 1'b0;
						pcnt_d  = 3'd0;
					end
					if (item_data.first) begin
						state_d = avc2ab_pkg::S_DIFF;
					end else if (kind_d != avc2ab_pkg::BK_NONE) begin
						state_d = avc2ab_pkg::S_BODY;
					end
				end
			end
			avc2ab_pkg::S_SCW: begin
				if (hdr_len_q < HB_L) begin
					ram_we    = 1'b1;
					ram_wdata = avc2ab_pkg::sc_byte(sc_q);
					hdr_len_d = hdr_len_q + LW'(1);
				end else begin
					ovf_d = 1'b1;
				end
				sc_d = sc_q + 2'd1;
				if (sc_q == 2'd3) begin
					state_d = avc2ab_pkg::S_IDLE;
				end
			end
			avc2ab_pkg::S_DIFF: begin
				diff_d  = ts_q - rts_q;
				state_d = avc2ab_pkg::S_EVAL;
			end
			avc2ab_pkg::S_EVAL: begin
				if (due) begin
					rsv_d  = tsv_q;
					rts_d  = ts_q;
					pend_d = 1'b0;
					idx_d  = '0;
					state_d = (hdr_len_q != '0) ? avc2ab_pkg::S_HRD : after_hdr;
				end else begin
					state_d = after_hdr;
				end
			end
			avc2ab_pkg::S_HRD: begin
				ram_re  = 1'b1;
				state_d = avc2ab_pkg::S_HOUT;
			end
			avc2ab_pkg::S_HOUT: begin
				if (can_emit) begin
					rl = hdr_last && (kind_q == avc2ab_pkg::BK_NONE);
					res_valid_d           = 1'b1;
					res_d.out_byte        = ram_rdata;
					res_d.run_last        = rl;
					res_d.is_header       = 1'b1;
					res_d.unit_end        = rl && last_q;
					res_d.header_overflow = ovf_q;
					idx_d   = idx_q + AW'(1);
					state_d = hdr_last ? after_hdr : avc2ab_pkg::S_HRD;
				end
			end
			avc2ab_pkg::S_BODY: begin
				if (can_emit) begin
					rl = (kind_q == avc2ab_pkg::BK_BYTE) || (sc_q == 2'd3);
					res_valid_d           = 1'b1;
					res_d.out_byte        = (kind_q == avc2ab_pkg::BK_BYTE) ? byte_q
						: avc2ab_pkg::sc_byte(sc_q);
					res_d.run_last        = rl;
					res_d.is_header       = 1'b0;
					res_d.unit_end        = rl && last_q;
					res_d.header_overflow = ovf_q;
					sc_d = sc_q + 2'd1;
					if (rl) begin
						state_d = avc2ab_pkg::S_IDLE;
					end
				end
			end
			default: begin
				state_d = avc2ab_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= avc2ab_pkg::S_IDLE;
			rec_q       <= avc2ab_pkg::RS_IDLE;
			skip_q      <= 2'd0;
			sets_q      <= 8'd0;
			in_pps_q    <= 1'b0;
			set_left_q  <= 16'd0;
			hdr_len_q   <= '0;
			ovf_q       <= 1'b0;
			len_size_q  <= 3'd4;
			pend_q      <= 1'b0;
			rsv_q       <= 1'b0;
			rts_q       <= '0;
			in_pl_q     <= 1'b0;
			pcnt_q      <= 3'd0;
			period_q    <= avc2ab_pkg::RESYNC_RESET;
			idx_q       <= '0;
			sc_q        <= 2'd0;
			kind_q      <= avc2ab_pkg::BK_NONE;
			res_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			rec_q       <= rec_d;
			skip_q      <= skip_d;
			sets_q      <= sets_d;
			in_pps_q    <= in_pps_d;
			set_left_q  <= set_left_d;
			hdr_len_q   <= hdr_len_d;
			ovf_q       <= ovf_d;
			len_size_q  <= len_size_d;
			pend_q      <= pend_d;
			rsv_q       <= rsv_d;
			rts_q       <= rts_d;
			in_pl_q     <= in_pl_d;
			pcnt_q      <= pcnt_d;
			period_q    <= period_d;
			idx_q       <= idx_d;
			sc_q        <= sc_d;
			kind_q      <= kind_d;
			res_valid_q <= res_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		psize_q <= psize_d;
		pacc_q  <= pacc_d;
		pleft_q <= pleft_d;
		byte_q  <= byte_d;
		last_q  <= last_d;
		tsv_q   <= tsv_d;
		ts_q    <= ts_d;
		diff_q  <= diff_d;
		res_q   <= res_d;
	end

endmodule

>>> hdl/avc2ab_checker.sv
// port-level checker for the converter core, bound to the top level
`include "avc_to_annexb_converter_core_macros.svh"

module avc2ab_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             item_ready,
	input logic             res_valid,
	input logic             res_ready,
	input avc2ab_pkg::out_t res_data
);

	// stalled result beat holds
	`A2B_ASSERT_NXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_data), "result beat changed while stalled")

	// overflow flag never clears once shown
	`A2B_ASSERT_NXT(a_ovf_sticky, res_valid && res_data.header_overflow, !res_valid || res_data.header_overflow, "header overflow flag cleared")

	`A2B_ASSERT_IMP(a_end_is_last, res_valid && res_data.unit_end, res_data.run_last, "unit end without run last")

	// more beats of the same item still to come
	`A2B_ASSERT_IMP(a_busy_mid_run, res_valid && !res_data.run_last, !item_ready, "ready while a run is unfinished")

endmodule

bind avc_to_annexb_converter_core avc2ab_checker u_avc2ab_checker (.*);
